FILE: hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared assertion forms for the median selection RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// The expression must hold in every cycle outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("invariant check failed");

`endif

FILE: hw/rtl/mols_pkg.sv
// ---------------------------------------------------------------------------
// mols_pkg
// Types and constants shared by the median selection block and its cells.
// ---------------------------------------------------------------------------
package mols_pkg;

    localparam int SAMPLE_W = 32;
    localparam int MEDIAN_W = 33;
    localparam int COUNT_W  = 7;

    typedef enum logic {
        ST_LOAD,
        ST_READ
    } t_state;

    typedef struct packed {
        logic load;
        logic shift;
    } t_cell_ctrl;

endpackage

FILE: hw/rtl/median_of_loaded_set_top.sv
// ---------------------------------------------------------------------------
// median_of_loaded_set_top
// Loads a set of samples into a sorted insertion chain and reports twice
// the median when the last sample arrives.
// ---------------------------------------------------------------------------
// A sample word is taken in any cycle in which start is high and busy is low,
// so samples may arrive back to back while busy is low. A sample that carries
// the last flag is stored in its own cycle, after which busy stays high while
// the chain shifts its words toward the first cell to reach the middle
// entries. The result word is marked by o_valid, which is high for a single
// cycle, the first cycle in which busy is low again, and the receiver cannot
// stall it.
// ---------------------------------------------------------------------------
module median_of_loaded_set_top #(
    parameter int MAX_SAMPLES = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [mols_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                          i_last_sample,
    output logic                          o_valid,
    output logic [mols_pkg::MEDIAN_W-1:0] o_median_twice,
    output logic [mols_pkg::COUNT_W-1:0]  o_sample_count,
    output logic                          o_overflowed
);
    import mols_pkg::*;

    `include "assert_macros.svh"

    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);

    t_state              r_state;
    t_state              n_state;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    n_count;
    logic                r_overflow;
    logic                n_overflow;
    logic [CNT_W-1:0]    r_shift;
    logic [CNT_W-1:0]    n_shift;
    logic [SAMPLE_W-1:0] r_lo;
    logic [SAMPLE_W-1:0] n_lo;
    logic                r_valid;
    logic                n_valid;
    logic [MEDIAN_W-1:0] r_median;
    logic [MEDIAN_W-1:0] n_median;
    logic [COUNT_W-1:0]  r_out_count;
    logic [COUNT_W-1:0]  n_out_count;
    logic                r_out_ovf;
    logic                n_out_ovf;

    logic                    w_accept;
    logic                    w_full;
    logic [CNT_W-1:0]        w_half;
    logic [CNT_W+COUNT_W-1:0] w_count_ext;
    t_cell_ctrl              w_ctrl;
    logic [SAMPLE_W-1:0]     w_val   [MAX_SAMPLES];
    logic                    w_above [MAX_SAMPLES];

    assign busy        = (r_state == ST_READ);
    assign w_accept    = start && !busy;
    assign w_full      = (r_count >= CNT_W'(MAX_SAMPLES));
    assign w_half      = r_count >> 1;
    assign w_count_ext = {{COUNT_W{1'b0}}, r_count};

    genvar g;
    generate
        for (g = 0; g < MAX_SAMPLES; g++) begin : g_cell
            logic [SAMPLE_W-1:0] w_left_val;
            logic                w_left_above;
            logic [SAMPLE_W-1:0] w_right_val;

            if (g == 0) begin : g_first
                assign w_left_val   = i_sample;
                assign w_left_above = 1'b0;
            end else begin : g_inner
                assign w_left_val   = w_val[g-1];
                assign w_left_above = w_above[g-1];
            end

            if (g == MAX_SAMPLES - 1) begin : g_last
                assign w_right_val = w_val[g];
            end else begin : g_body
                assign w_right_val = w_val[g+1];
            end

            mols_cell u_cell (
                .i_clk        (i_clk),
                .i_ctrl       (w_ctrl),
                .i_valid      (r_count > CNT_W'(g)),
                .i_sample     (i_sample),
                .i_left_val   (w_left_val),
                .i_left_above (w_left_above),
                .i_right_val  (w_right_val),
                .o_val        (w_val[g]),
                .o_above      (w_above[g])
            );
        end
    endgenerate

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_overflow  = r_overflow;
        n_shift     = r_shift;
        n_lo        = r_lo;
        n_valid     = 1'b0;
        n_median    = r_median;
        n_out_count = r_out_count;
        n_out_ovf   = r_out_ovf;
        w_ctrl      = '{load: 1'b0, shift: 1'b0};

        unique case (r_state)
            ST_LOAD: begin
                n_shift = '0;
                if (w_accept) begin
                    if (w_full) begin
                        n_overflow = 1'b1;
                    end else begin
                        w_ctrl.load = 1'b1;
                        n_count     = r_count + 1'b1;
                    end
                    if (i_last_sample) begin
                        n_state = ST_READ;
                    end
                end
            end
            ST_READ: begin
                w_ctrl.shift = 1'b1;
                n_shift      = r_shift + 1'b1;
                if (!r_count[0] && (r_shift == w_half - 1'b1)) begin
                    n_lo = w_val[0];
                end
                if (r_shift == w_half) begin
                    n_valid     = 1'b1;
                    n_median    = r_count[0] ? {w_val[0], 1'b0}
                                             : {1'b0, r_lo} + {1'b0, w_val[0]};
                    n_out_count = w_count_ext[COUNT_W-1:0];
                    n_out_ovf   = r_overflow;
                    n_count     = '0;
                    n_overflow  = 1'b0;
                    n_state     = ST_LOAD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_LOAD;
            r_count    <= '0;
            r_overflow <= 1'b0;
            r_shift    <= '0;
            r_valid    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_overflow <= n_overflow;
            r_shift    <= n_shift;
            r_valid    <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo        <= n_lo;
        r_median    <= n_median;
        r_out_count <= n_out_count;
        r_out_ovf   <= n_out_ovf;
    end

    assign o_valid        = r_valid;
    assign o_median_twice = r_median;
    assign o_sample_count = r_out_count;
    assign o_overflowed   = r_out_ovf;

    `ASSERT_IMPLY(a_read_has_samples, i_clk, i_rst_n, busy, r_count != '0)
    `ASSERT_IMPLY(a_result_after_read, i_clk, i_rst_n, o_valid, $past(busy) && !busy)
    `ASSERT_ALWAYS(a_count_in_range, i_clk, i_rst_n, r_count <= CNT_W'(MAX_SAMPLES))
    `ASSERT_IMPLY(a_shift_bounded, i_clk, i_rst_n, busy, r_shift <= w_half)

endmodule

FILE: hw/rtl/mols_cell.sv
// ---------------------------------------------------------------------------
// mols_cell
// One slot of the sorted insertion chain. On a load it keeps its word, takes
// the new sample or takes its left neighbor's word; on a shift it takes its
// right neighbor's word.
// ---------------------------------------------------------------------------
module mols_cell (
    input  logic                          i_clk,
    input  mols_pkg::t_cell_ctrl          i_ctrl,
    input  logic                          i_valid,
    input  logic [mols_pkg::SAMPLE_W-1:0] i_sample,
    input  logic [mols_pkg::SAMPLE_W-1:0] i_left_val,
    input  logic                          i_left_above,
    input  logic [mols_pkg::SAMPLE_W-1:0] i_right_val,
    output logic [mols_pkg::SAMPLE_W-1:0] o_val,
    output logic                          o_above
);
    import mols_pkg::*;

    logic [SAMPLE_W-1:0] r_val;
    logic [SAMPLE_W-1:0] n_val;

    assign o_above = !i_valid || (r_val > i_sample);
    assign o_val   = r_val;

    always_comb begin
        n_val = r_val;
        if (i_ctrl.shift) begin
            n_val = i_right_val;
        end else if (i_ctrl.load && o_above) begin
            n_val = i_left_above ? i_left_val : i_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule
